[sv/ssbg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbg_pkg: shared types and constants of the spectral subtraction gain engine
// Payload structs, opcodes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package ssbg_pkg;

   localparam int NUM_BINS   = 257;
   localparam int BIN_W      = 9;
   localparam int ADDR_W     = $clog2(NUM_BINS);
   localparam int DATA_W     = 24;
   localparam int GAIN_W     = 17;
   localparam int SQ_W       = 48;
   localparam int DIV_N_W    = 48;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);

   localparam logic [15:0] SNR_THRESHOLD_RST    = 16'd512;
   localparam logic [15:0] OVER_SUBTRACTION_RST = 16'd8192;
   localparam logic [15:0] GAIN_FLOOR_RST       = 16'd655;

   localparam logic [1:0] REG_SNR_THRESHOLD    = 2'd0;
   localparam logic [1:0] REG_OVER_SUBTRACTION = 2'd1;
   localparam logic [1:0] REG_GAIN_FLOOR       = 2'd2;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_PROCESS = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic [BIN_W-1:0]         bin_index;
      logic signed [DATA_W-1:0] bin_real;
      logic signed [DATA_W-1:0] bin_imag;
      logic [DATA_W-1:0]        noise_level;
      logic                     profile_done;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_real;
      logic signed [DATA_W-1:0] out_imag;
      logic [GAIN_W-1:0]        applied_gain;
      logic [DATA_W-1:0]        bin_magnitude;
   } rsp_type;

   // Work handed from front to back: one process item; its noise entry goes beside it
   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic                     use_noise;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_CMP,
      ST_DIV,
      ST_SCALE,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic [15:0] snr_threshold;
      logic [15:0] over_subtraction;
      logic [15:0] gain_floor;
   } cfg_type;

endpackage

[sv/ssbg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ssbg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ssbg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbg_front: accepts items, applies noise writes, queues process items
// Writes go to the noise table; process items read their noise entry and
// enter a small queue together with it.
// ----------------------------------------------------------------------------
module ssbg_front import ssbg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   input  logic                job_pop,
   output logic                job_valid,
   output job_type             job_data,
   output logic [DATA_W-1:0]   job_noise
);

   logic                 accept;
   logic                 in_range;
   logic                 profile_ready_ff, profile_ready_in;
   logic                 stage_valid_ff, stage_valid_in;
   job_type              stage_job_ff, stage_job_in;
   job_type              q_job_ff [QUEUE_DEPTH];
   logic [DATA_W-1:0]    q_noise_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic [DATA_W-1:0]    rd_noise;
   logic                 push;

   assign accept   = start && !busy;
   assign in_range = {1'b0, req_data.bin_index} < (BIN_W+1)'(NUM_BINS);
   // Leave room for the item in the read stage
   assign busy     = (count_ff + {{QPTR_W{1'b0}}, stage_valid_ff}) >=
                     (QPTR_W+1)'(QUEUE_DEPTH);
   assign push     = stage_valid_ff;

   ssbg_ram #(.WIDTH(DATA_W), .DEPTH(NUM_BINS)) u_noise_ram (
      .clock  (clock),
      .wr_en  (accept && req_data.opcode == OP_WRITE && in_range),
      .wr_addr(ADDR_W'(req_data.bin_index)),
      .wr_data(req_data.noise_level),
      .rd_addr(ADDR_W'(req_data.bin_index)),
      .rd_data(rd_noise)
   );

   // Classify accepted items
   always_comb begin
      profile_ready_in = profile_ready_ff;
      stage_valid_in   = 1'b0;
      stage_job_in     = stage_job_ff;
      if (accept) begin
         if (req_data.opcode == OP_WRITE) begin
            if (req_data.profile_done) begin
               profile_ready_in = 1'b1;
            end
         end else begin
            stage_valid_in         = 1'b1;
            stage_job_in.re        = req_data.bin_real;
            stage_job_in.im        = req_data.bin_imag;
            stage_job_in.use_noise = profile_ready_ff && in_range;
         end
      end
   end

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = job_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ready_ff <= 1'b0;
         stage_valid_ff   <= 1'b0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         profile_ready_ff <= profile_ready_in;
         stage_valid_ff   <= stage_valid_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         count_ff         <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      stage_job_ff <= stage_job_in;
      if (push) begin
         q_job_ff[wr_ptr_ff]   <= stage_job_ff;
         q_noise_ff[wr_ptr_ff] <= rd_noise;
      end
   end

   assign job_valid = count_ff != '0;
   assign job_data  = q_job_ff[rd_ptr_ff];
   assign job_noise = q_noise_ff[rd_ptr_ff];

endmodule

[sv/ssbg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbg_back: magnitude, gain and scaling for one process item at a time
// Bit-pair square root (24 steps), restoring divide (48 steps) when the gain
// is computed, then two scaling multiplies and the result strobe.
// ----------------------------------------------------------------------------
module ssbg_back import ssbg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              job_valid,
   input  job_type           job_data,
   input  logic [DATA_W-1:0] job_noise,
   output logic              job_pop,
   output logic              rsp_strobe,
   output rsp_type           rsp_data
);

   back_state_type       state_ff, state_in;
   logic [5:0]           step_ff, step_in;
   logic signed [DATA_W-1:0] re_ff, im_ff;
   logic                 use_noise_ff;
   logic [DATA_W-1:0]    noise_ff;
   logic [SQ_W-1:0]      sq_ff, sq_in;        // radicand remainder
   logic [SQ_W-1:0]      sq_rem_ff, sq_rem_in;
   logic [DATA_W-1:0]    root_ff, root_in;
   logic [DIV_N_W-1:0]   num_ff, num_in;
   logic [DATA_W:0]      drem_ff, drem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic [DATA_W-1:0]    abs_re_ff, abs_im_ff;
   logic [DATA_W+GAIN_W-1:0] prod_re_ff, prod_im_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;

   logic [SQ_W-1:0]      sq_trial;
   logic [SQ_W-1:0]      sq_shift;
   logic [DATA_W+1:0]    root_trial;
   logic [DATA_W:0]      drem_shift;
   logic [DATA_W+7:0]    lhs;
   logic [DATA_W+15:0]   rhs;
   logic [DATA_W-1:0]    r_re, r_im;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (job_valid) state_in = ST_SQRT;
         ST_SQRT:  if (step_ff == 6'd23) state_in = ST_CMP;
         ST_CMP:   state_in = (use_noise_ff && lhs > rhs) ? ST_DIV : ST_SCALE;
         ST_DIV:   if (step_ff == 6'd47) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign sq_shift   = {sq_rem_ff[SQ_W-3:0], sq_ff[SQ_W-1 -: 2]};
   assign root_trial = {root_ff, 2'b01};
   assign sq_trial   = sq_shift - SQ_W'(root_trial);
   assign drem_shift = {drem_ff[DATA_W-1:0], num_ff[DIV_N_W-1]};
   assign lhs        = {root_ff, 8'd0};
   assign rhs        = cfg.snr_threshold * noise_ff;

   // Datapath updates per state
   always_comb begin
      step_in   = step_ff;
      sq_in     = sq_ff;
      sq_rem_in = sq_rem_ff;
      root_in   = root_ff;
      num_in    = num_ff;
      drem_in   = drem_ff;
      quo_in    = quo_ff;
      gain_in   = gain_ff;
      job_pop   = 1'b0;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in   = '0;
            sq_in     = SQ_W'(job_data.re * job_data.re) + SQ_W'(job_data.im * job_data.im);
            sq_rem_in = '0;
            root_in   = '0;
            job_pop   = job_valid;
         end
         ST_SQRT: begin
            step_in = step_ff + 1'b1;
            sq_in   = {sq_ff[SQ_W-3:0], 2'b00};
            if (!sq_trial[SQ_W-1] && sq_shift >= SQ_W'(root_trial)) begin
               sq_rem_in = sq_trial;
               root_in   = {root_ff[DATA_W-2:0], 1'b1};
            end else begin
               sq_rem_in = sq_shift;
               root_in   = {root_ff[DATA_W-2:0], 1'b0};
            end
         end
         ST_CMP: begin
            step_in = '0;
            gain_in = UNITY_GAIN;
            if (use_noise_ff) begin
               gain_in = GAIN_W'(cfg.gain_floor);
            end
            // numerator = alpha*noise*16 + mag/2
            num_in  = DIV_N_W'({(DATA_W+16)'(cfg.over_subtraction) *
                                (DATA_W+16)'(noise_ff), 4'd0}) +
                      DIV_N_W'(root_ff >> 1);
            drem_in = '0;
            quo_in  = '0;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            num_in  = {num_ff[DIV_N_W-2:0], 1'b0};
            if (drem_shift >= {1'b0, root_ff}) begin
               drem_in = drem_shift - {1'b0, root_ff};
               quo_in  = {quo_ff[DIV_N_W-2:0], 1'b1};
            end else begin
               drem_in = drem_shift;
               quo_in  = {quo_ff[DIV_N_W-2:0], 1'b0};
            end
            if (step_ff == 6'd47) begin
               if (quo_in > DIV_N_W'(UNITY_GAIN) ||
                   (UNITY_GAIN - GAIN_W'(quo_in)) < GAIN_W'(cfg.gain_floor)) begin
                  gain_in = GAIN_W'(cfg.gain_floor);
               end else begin
                  gain_in = UNITY_GAIN - GAIN_W'(quo_in);
               end
            end
         end
         ST_SCALE: ;
         ST_OUT: begin
            strobe_in            = 1'b1;
            rsp_in.out_real      = re_ff[DATA_W-1] ? -r_re : r_re;
            rsp_in.out_imag      = im_ff[DATA_W-1] ? -r_im : r_im;
            rsp_in.applied_gain  = gain_ff;
            rsp_in.bin_magnitude = root_ff;
         end
         default: ;
      endcase
   end

   // Round half away from zero on the magnitudes
   assign r_re = DATA_W'((prod_re_ff + (DATA_W+GAIN_W)'(32768)) >> 16);
   assign r_im = DATA_W'((prod_im_ff + (DATA_W+GAIN_W)'(32768)) >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      sq_ff     <= sq_in;
      sq_rem_ff <= sq_rem_in;
      root_ff   <= root_in;
      num_ff    <= num_in;
      drem_ff   <= drem_in;
      quo_ff    <= quo_in;
      gain_ff   <= gain_in;
      rsp_ff    <= rsp_in;
      if (state_ff == ST_IDLE) begin
         re_ff        <= job_data.re;
         im_ff        <= job_data.im;
         use_noise_ff <= job_data.use_noise;
         noise_ff     <= job_noise;
         abs_re_ff    <= job_data.re[DATA_W-1] ? DATA_W'(-job_data.re) : job_data.re;
         abs_im_ff    <= job_data.im[DATA_W-1] ? DATA_W'(-job_data.im) : job_data.im;
      end
      if (state_ff == ST_SCALE) begin
         prod_re_ff <= abs_re_ff * gain_ff;
         prod_im_ff <= abs_im_ff * gain_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[sv/spectral_subtraction_bin_gain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_subtraction_bin_gain: per-bin spectral subtraction gain engine
// Usage:
//   Request channel: an item transfers when start is high and busy is low.
//   A write item (opcode 0) stores a noise magnitude for its bin and may
//   mark the profile ready; it gives no result. A process item (opcode 1)
//   gives one result, shown on rsp_data for one cycle with rsp_strobe.
//   The front accepts one item per cycle while busy is low and queues process
//   items in a four-entry queue; the back works one process item at a time:
//   load, square root, compare, restoring divide when the gain is computed,
//   then scale and output. Sustained throughput is set by the back, which
//   takes no new item before its last result is out.
//   Writes do not occupy the back.
//   Configuration registers sit on the APB-style port at byte 0, 4 and 8.
//   Reset clears the profile-ready flag, the queue and the registers to
//   their defaults; the noise table holds garbage until written.
//   The receiver cannot stall: results are never held back.
// ----------------------------------------------------------------------------
module spectral_subtraction_bin_gain import ssbg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type           cfg_ff, cfg_in;
   logic              job_valid, job_pop;
   job_type           job_data;
   logic [DATA_W-1:0] job_noise;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (paddr[3:2])
            REG_SNR_THRESHOLD:    cfg_in.snr_threshold    = pwdata[15:0];
            REG_OVER_SUBTRACTION: cfg_in.over_subtraction = pwdata[15:0];
            REG_GAIN_FLOOR:       cfg_in.gain_floor       = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{SNR_THRESHOLD_RST, OVER_SUBTRACTION_RST, GAIN_FLOOR_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      prdata = '0;
      unique case (paddr[3:2])
         REG_SNR_THRESHOLD:    prdata = {16'd0, cfg_ff.snr_threshold};
         REG_OVER_SUBTRACTION: prdata = {16'd0, cfg_ff.over_subtraction};
         REG_GAIN_FLOOR:       prdata = {16'd0, cfg_ff.gain_floor};
         default: ;
      endcase
   end

   ssbg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .job_pop  (job_pop),
      .job_valid(job_valid),
      .job_data (job_data),
      .job_noise(job_noise)
   );

   ssbg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_noise (job_noise),
      .job_pop   (job_pop),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/ssbg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbg_props: port-level checks of the gain engine
// Watches results and configuration port behavior over time.
// ----------------------------------------------------------------------------
module ssbg_props import ssbg_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_strobe,
   input rsp_type rsp_data,
   input logic    pready
);

   // Results never come back to back: the back handles one item at a time
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   // Gain never exceeds unity
   a_gain_max: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.applied_gain <= UNITY_GAIN)
      else $error("gain above unity");

   // With unity gain, a zero magnitude gives a zero output
   a_unity_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.applied_gain == UNITY_GAIN |->
         rsp_data.bin_magnitude != '0 || (rsp_data.out_real == '0 && rsp_data.out_imag == '0))
      else $error("nonzero output with zero magnitude");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result right after reset");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind spectral_subtraction_bin_gain ssbg_props u_ssbg_props (
   .clock     (clock),
   .reset     (reset),
   .rsp_strobe(rsp_strobe),
   .rsp_data  (rsp_data),
   .pready    (pready)
);
